// ----- rtl/otq_pkg.sv -----
package otq_pkg;

  localparam int unsigned CAPACITY = 16;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_SCHED_C  = 3'd1;
  localparam logic [2:0] OP_SCHED_X  = 3'd2;
  localparam logic [2:0] OP_CANCEL   = 3'd3;
  localparam logic [2:0] OP_DISPOSE  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REFUSED   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] delay_ms;
    logic [31:0] cancel_handle;
    logic [31:0] user_data;
    logic [15:0] handler_tag;
    logic [7:0]  executor_tag;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] handle;
    logic [31:0] fired_data;
    logic [15:0] fired_handler;
    logic [7:0]  fired_executor;
    logic        is_execute;
    logic        shutdown;
    logic [1:0]  status;
    logic [4:0]  pending;
    logic        busy_res;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [47:0] deadline;
    logic [31:0] handle;
    logic [31:0] data;
    logic [15:0] handler;
    logic [7:0]  executor;
    logic        exec_kind;
    logic [31:0] order;
  } slot_t;

endpackage

// ----- rtl/otq_ram.sv -----
module otq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/otq_pick.sv -----
module otq_pick import otq_pkg::*; (
  input  slot_t       cand_i,
  input  logic        cand_valid_i,
  input  slot_t       best_i,
  input  logic        have_best_i,
  input  logic [47:0] now_i,
  input  logic [31:0] insert_count_i,
  input  logic        everything_i,
  output logic        take_o
);

  logic        due;
  logic        earlier;
  logic [31:0] rel_cand;
  logic [31:0] rel_best;

  always_comb begin
    rel_cand = cand_i.order - insert_count_i;
    rel_best = best_i.order - insert_count_i;
    due      = everything_i || (cand_i.deadline <= now_i);
    if (cand_i.deadline != best_i.deadline) begin
      earlier = cand_i.deadline < best_i.deadline;
    end else begin
      earlier = rel_cand < rel_best;
    end
    take_o = cand_valid_i && due && (!have_best_i || earlier);
  end

endmodule

// ----- rtl/one_shot_timer_queue.sv -----
// channel   | signals                    | transfer
// ----------+----------------------------+-----------------------------------
// request   | start, busy, req_i         | edge with start high, busy low
// result    | res_valid_o, res_o         | every edge ending a res_valid_o cycle
//
// timers live in one ram with registered read; each search pass walks the slots
// in order, one read a cycle.
// tick and dispose run one pass per fired timer plus a final pass; schedule
// walks valid bits for a free slot; cancel is one pass at most.
// reset at once clears valid bits, clock, order counter; handle counter goes to 1.
// results come out one per cycle as produced; the receiver cannot stall.
module one_shot_timer_queue import otq_pkg::*; #(
  parameter int unsigned Capacity = CAPACITY
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned IW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DRAIN  = 3'd1;
  localparam logic [2:0] S_FREE   = 3'd2;
  localparam logic [2:0] S_CANCEL = 3'd3;
  localparam logic [2:0] S_ACK    = 3'd4;

  logic [2:0]          state_q, state_d;
  req_t                req_q, req_d;
  logic [47:0]         now_q, now_d;
  logic [31:0]         nh_q, nh_d;
  logic [31:0]         ins_q, ins_d;
  logic                disp_q, disp_d;
  logic [Capacity-1:0] valid_q, valid_d;
  logic [CW-1:0]       count_q, count_d;
  logic [IW:0]         idx_q, idx_d;
  logic                pend_q, pend_d;
  logic [IW-1:0]       pidx_q, pidx_d;
  logic                have_q, have_d;
  slot_t               best_q, best_d;
  logic [IW-1:0]       bidx_q, bidx_d;
  logic [1:0]          ast_q, ast_d;
  logic                rv_q, rv_d;
  res_t                res_q, res_d;

  logic        issue;
  logic        we;
  slot_t       wslot;
  slot_t       rslot;
  logic        take;
  logic [48:0] dl_sum;
  logic [31:0] nh_inc;
  logic [31:0] cnt_ext;

  assign issue = idx_q < (IW+1)'(Capacity);

  otq_ram #(
    .Width ($bits(slot_t)),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q[IW-1:0]),
    .wdata_i (wslot),
    .re_i    (issue),
    .raddr_i (idx_q[IW-1:0]),
    .rdata_o (rslot)
  );

  otq_pick u_pick (
    .cand_i         (rslot),
    .cand_valid_i   (pend_q && valid_q[pidx_q]),
    .best_i         (best_q),
    .have_best_i    (have_q),
    .now_i          (now_q),
    .insert_count_i (ins_q),
    .everything_i   (req_q.opcode == OP_DISPOSE),
    .take_o         (take)
  );

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    now_d   = now_q;
    nh_d    = nh_q;
    ins_d   = ins_q;
    disp_d  = disp_q;
    valid_d = valid_q;
    count_d = count_q;
    idx_d   = idx_q;
    pend_d  = 1'b0;
    pidx_d  = pidx_q;
    have_d  = have_q;
    best_d  = best_q;
    bidx_d  = bidx_q;
    ast_d   = ast_q;
    rv_d    = 1'b0;
    res_d   = '0;
    we      = 1'b0;

    dl_sum = {1'b0, now_q} + 49'(req_q.delay_ms);
    nh_inc = nh_q + 32'd1;
    wslot.deadline  = dl_sum[48] ? '1 : dl_sum[47:0];
    wslot.handle    = (req_q.opcode == OP_SCHED_X) ? 32'd0 : nh_q;
    wslot.data      = req_q.user_data;
    wslot.handler   = req_q.handler_tag;
    wslot.executor  = (req_q.opcode == OP_SCHED_X) ? req_q.executor_tag : 8'd0;
    wslot.exec_kind = req_q.opcode == OP_SCHED_X;
    wslot.order     = ins_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d  = req_i;
          idx_d  = '0;
          have_d = 1'b0;
          ast_d  = ST_OK;
          unique case (req_i.opcode)
            OP_TICK: begin
              now_d   = now_q + 48'd1;
              state_d = S_DRAIN;
            end
            OP_SCHED_C, OP_SCHED_X: begin
              if (req_i.handler_tag == 16'd0) begin
                ast_d   = ST_REFUSED;
                state_d = S_ACK;
              end else if (disp_q) begin
                ast_d   = ST_REFUSED;
                state_d = S_ACK;
                if (req_i.opcode == OP_SCHED_X) begin
                  rv_d                 = 1'b1;
                  res_d.kind           = 1'b1;
                  res_d.fired_data     = req_i.user_data;
                  res_d.fired_handler  = req_i.handler_tag;
                  res_d.fired_executor = req_i.executor_tag;
                  res_d.is_execute     = 1'b1;
                  res_d.shutdown       = 1'b1;
                end
              end else begin
                state_d = S_FREE;
              end
            end
            OP_CANCEL: begin
              state_d = (req_i.cancel_handle == 32'd0) ? S_ACK : S_CANCEL;
            end
            OP_DISPOSE: begin
              disp_d  = 1'b1;
              state_d = S_DRAIN;
            end
            default: state_d = S_ACK;
          endcase
        end
      end
      S_DRAIN: begin
        if (issue) begin
          pend_d = 1'b1;
          pidx_d = idx_q[IW-1:0];
          idx_d  = idx_q + (IW+1)'(1);
        end
        if (take) begin
          have_d = 1'b1;
          best_d = rslot;
          bidx_d = pidx_q;
        end
        if (!issue && !pend_q) begin
          rv_d = 1'b1;
          if (have_q) begin
            valid_d[bidx_q]      = 1'b0;
            count_d              = count_q - CW'(1);
            idx_d                = '0;
            have_d               = 1'b0;
            res_d.kind           = 1'b1;
            res_d.handle         = best_q.handle;
            res_d.fired_data     = best_q.data;
            res_d.fired_handler  = best_q.handler;
            res_d.fired_executor = best_q.executor;
            res_d.is_execute     = best_q.exec_kind;
            res_d.shutdown       = req_q.opcode == OP_DISPOSE;
          end else begin
            res_d.last = 1'b1;
            state_d    = S_IDLE;
          end
        end
      end
      S_FREE: begin
        if (!valid_q[idx_q[IW-1:0]]) begin
          we                     = 1'b1;
          valid_d[idx_q[IW-1:0]] = 1'b1;
          count_d                = count_q + CW'(1);
          ins_d                  = ins_q + 32'd1;
          if (req_q.opcode == OP_SCHED_C) begin
            res_d.handle = nh_q;
            nh_d         = (nh_inc == 32'd0) ? 32'd1 : nh_inc;
          end
          rv_d       = 1'b1;
          res_d.last = 1'b1;
          state_d    = S_IDLE;
        end else if (idx_q == (IW+1)'(Capacity - 1)) begin
          rv_d         = 1'b1;
          res_d.last   = 1'b1;
          res_d.status = ST_FULL;
          state_d      = S_IDLE;
        end else begin
          idx_d = idx_q + (IW+1)'(1);
        end
      end
      S_CANCEL: begin
        if (issue) begin
          pend_d = 1'b1;
          pidx_d = idx_q[IW-1:0];
          idx_d  = idx_q + (IW+1)'(1);
        end
        if (pend_q && valid_q[pidx_q] && !rslot.exec_kind
            && rslot.handle == req_q.cancel_handle) begin
          valid_d[pidx_q] = 1'b0;
          count_d         = count_q - CW'(1);
          pend_d          = 1'b0;
          rv_d            = 1'b1;
          res_d.last      = 1'b1;
          res_d.handle    = req_q.cancel_handle;
          state_d         = S_IDLE;
        end else if (!issue && !pend_q) begin
          rv_d         = 1'b1;
          res_d.last   = 1'b1;
          res_d.status = ST_NOT_FOUND;
          state_d      = S_IDLE;
        end
      end
      S_ACK: begin
        rv_d         = 1'b1;
        res_d.last   = 1'b1;
        res_d.status = ast_q;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    cnt_ext        = 32'(count_d);
    res_d.pending  = cnt_ext[4:0];
    res_d.busy_res = count_d != '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      now_q   <= '0;
      nh_q    <= 32'd1;
      ins_q   <= '0;
      disp_q  <= 1'b0;
      valid_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      have_q  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      nh_q    <= nh_d;
      ins_q   <= ins_d;
      disp_q  <= disp_d;
      valid_q <= valid_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      have_q  <= have_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pidx_q <= pidx_d;
    best_q <= best_d;
    bidx_q <= bidx_d;
    ast_q  <= ast_d;
    res_q  <= res_d;
  end

  assign busy        = state_q != S_IDLE;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/otq_checker.sv -----
module otq_checker import otq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic res_valid_o,
  input res_t res_o
);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("transfer did not raise busy");

  a_ack_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy)
    else $error("busy after final result");

  a_event_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind |-> busy && !res_o.last && res_o.status == ST_OK)
    else $error("malformed expiry event");

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.kind |-> res_o.last && !res_o.shutdown)
    else $error("ack not marked last");

endmodule

bind one_shot_timer_queue otq_checker u_otq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
